FILE: design/arpa_pkg.sv
// arpa_pkg: shared constants, codes and control types of the region pool allocator
// used by every module under design/; depends on nothing
package arpa_pkg;

  localparam int MAX_REGIONS = 16;
  localparam int SPACE_BITS  = 20;
  localparam int IDX_W       = $clog2(MAX_REGIONS);
  localparam int CNT_W       = IDX_W + 1;
  localparam int ADDR_W      = SPACE_BITS + 1;
  localparam int LEN_W       = 20;
  localparam int CC_W        = 16;
  localparam int STEP_W      = $clog2(ADDR_W + 1);
  localparam int IN_DATA_W   = 24;
  localparam int OUT_DATA_W  = 32;

  localparam logic [ADDR_W-1:0] SPACE_SIZE  = ADDR_W'(1) << SPACE_BITS;
  localparam logic [ADDR_W-1:0] DEF_INITIAL = ADDR_W'(512);
  localparam logic [ADDR_W-1:0] DEF_INCR    = ADDR_W'(128);
  localparam logic [CC_W-1:0]   DEF_INTERVAL = CC_W'(100);
  localparam logic [ADDR_W-1:0] MTF_SLACK   = ADDR_W'(128);

  // divide by ten as multiply by ceil(2^23 / 10) and shift, exact below 2^21
  localparam int          RECIP_SH = 23;
  localparam logic [19:0] RECIP10  = 20'hCCCCD;

  localparam logic [1:0] MODE_ALLOC = 2'd0;
  localparam logic [1:0] MODE_FORCE = 2'd2;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_SPACE = 2'd2;

  localparam logic [1:0] REG_INITIAL  = 2'd0;
  localparam logic [1:0] REG_INCR     = 2'd1;
  localparam logic [1:0] REG_INTERVAL = 2'd2;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_STEP, OP_FOUND, OP_ERR_FULL, OP_DIV_T10, OP_ERR_SPACE,
    OP_APPEND, OP_GRANT, OP_DIV_FREM, OP_MTF, OP_CLR_START, OP_RA_SUB, OP_RA_ADD,
    OP_FORCE, OP_DIV_SZ, OP_RESIZE, OP_RELOC, OP_OUT
  } op_t;

  typedef enum logic [1:0] {RSEL_SCAN, RSEL_SLOT, RSEL_FRONT} rsel_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DISP, ST_SCAN, ST_T10W, ST_GRANT, ST_FREM, ST_FREMW, ST_CLR,
    ST_RAW, ST_TW, ST_DECIDE, ST_SZW, ST_RELOC, ST_OUT
  } state_t;

  typedef struct packed {
    op_t   op;
    rsel_t rsel;
  } cmd_t;

  typedef struct packed {
    logic is_alloc;
    logic forced;
    logic fits;
    logic scan_end;
    logic table_full;
    logic too_big;
    logic p_zero;
    logic mtf_ok;
    logic unused;
    logic at_interval;
    logic div_done;
    logic out_free;
  } stat_t;

  function automatic logic [ADDR_W-1:0] pad8(input logic [ADDR_W-1:0] a);
    logic [ADDR_W-1:0] s;
    s = a + ADDR_W'(7);
    return s & ~ADDR_W'(7);
  endfunction

  function automatic logic [ADDR_W-1:0] div10(input logic [ADDR_W-1:0] a);
    logic [ADDR_W+19:0] prod;
    prod = (ADDR_W+20)'(a) * (ADDR_W+20)'(RECIP10);
    return ADDR_W'(prod >> RECIP_SH);
  endfunction

endpackage

FILE: design/arpa_div.sv
// arpa_div: restoring divider, one quotient bit per cycle
// depends on arpa_pkg
module arpa_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [arpa_pkg::ADDR_W-1:0]   dividend,
  input  logic [arpa_pkg::CC_W-1:0]     divisor,
  output logic [arpa_pkg::ADDR_W-1:0]   quotient,
  output logic                          busy
);
  import arpa_pkg::*;

  logic [ADDR_W-1:0] quo_r, quo_nxt;
  logic [CC_W-1:0]   rem_r, rem_nxt, div_r;
  logic [STEP_W-1:0] cnt_r;
  logic              busy_r;
  logic [CC_W:0]     sh;
  logic              ge;

  always_comb begin
    sh      = {rem_r, quo_r[ADDR_W-1]};
    ge      = sh >= {1'b0, div_r};
    rem_nxt = ge ? CC_W'(sh - {1'b0, div_r}) : sh[CC_W-1:0];
    quo_nxt = {quo_r[ADDR_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= STEP_W'(ADDR_W);
      quo_r  <= dividend;
      rem_r  <= '0;
      div_r  <= divisor;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
      cnt_r <= cnt_r - STEP_W'(1);
      if (cnt_r == STEP_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign quotient = quo_r;
  assign busy     = busy_r;

endmodule

FILE: design/arpa_ctrl.sv
// arpa_ctrl: sequencer of the allocator; issues one datapath command per cycle
// depends on arpa_pkg
module arpa_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  arpa_pkg::stat_t stat,
  output arpa_pkg::cmd_t  cmd
);
  import arpa_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_tvalid) state_nxt = ST_DISP;
      ST_DISP:   state_nxt = stat.is_alloc ? ST_SCAN : ST_CLR;
      ST_SCAN: begin
        if (stat.scan_end) begin
          state_nxt = stat.table_full ? ST_OUT : ST_T10W;
        end else if (stat.fits) begin
          state_nxt = ST_GRANT;
        end
      end
      ST_T10W:   if (stat.div_done) state_nxt = stat.too_big ? ST_OUT : ST_GRANT;
      ST_GRANT:  state_nxt = stat.p_zero ? ST_OUT : ST_FREM;
      ST_FREM:   state_nxt = ST_FREMW;
      ST_FREMW:  if (stat.div_done) state_nxt = ST_OUT;
      ST_CLR:    state_nxt = stat.unused ? ST_OUT : ST_RAW;
      ST_RAW:    if (stat.div_done) state_nxt = ST_TW;
      ST_TW:     if (stat.div_done) state_nxt = ST_DECIDE;
      ST_DECIDE: begin
        if (stat.forced) state_nxt = ST_RELOC;
        else if (stat.at_interval) state_nxt = ST_SZW;
        else state_nxt = ST_RELOC;
      end
      ST_SZW:    if (stat.div_done) state_nxt = ST_RELOC;
      ST_RELOC:  state_nxt = ST_OUT;
      ST_OUT:    if (stat.out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.op    = OP_NONE;
    cmd.rsel  = RSEL_SCAN;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) cmd.op = OP_LOAD;
      end
      ST_DISP: cmd.op = OP_NONE;
      ST_SCAN: begin
        cmd.rsel = RSEL_SCAN;
        if (stat.scan_end) cmd.op = stat.table_full ? OP_ERR_FULL : OP_DIV_T10;
        else if (stat.fits) cmd.op = OP_FOUND;
        else cmd.op = OP_STEP;
      end
      ST_T10W: if (stat.div_done) cmd.op = stat.too_big ? OP_ERR_SPACE : OP_APPEND;
      ST_GRANT: begin
        cmd.rsel = RSEL_SLOT;
        cmd.op   = OP_GRANT;
      end
      ST_FREM: begin
        cmd.rsel = RSEL_FRONT;
        cmd.op   = OP_DIV_FREM;
      end
      ST_FREMW: if (stat.div_done && stat.mtf_ok) cmd.op = OP_MTF;
      ST_CLR: begin
        cmd.rsel = RSEL_FRONT;
        if (!stat.unused) cmd.op = OP_CLR_START;
      end
      ST_RAW: if (stat.div_done) cmd.op = OP_RA_SUB;
      ST_TW:  if (stat.div_done) cmd.op = OP_RA_ADD;
      ST_DECIDE: begin
        if (stat.forced) cmd.op = OP_FORCE;
        else if (stat.at_interval) cmd.op = OP_DIV_SZ;
      end
      ST_SZW:   if (stat.div_done) cmd.op = OP_RESIZE;
      ST_RELOC: cmd.op = OP_RELOC;
      ST_OUT:   if (stat.out_free) cmd.op = OP_OUT;
      default:  cmd.op = OP_NONE;
    endcase
  end

endmodule

FILE: design/arpa_dp.sv
// arpa_dp: region table, counters, config registers, output register and divider
// depends on arpa_pkg and arpa_div
module arpa_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [1:0]                       in_tuser,
  input  logic [arpa_pkg::IN_DATA_W-1:0]   in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [arpa_pkg::OUT_DATA_W-1:0]  out_tdata,
  input  logic                             cfg_valid,
  input  logic [1:0]                       cfg_index,
  input  logic [arpa_pkg::LEN_W-1:0]       cfg_data,
  input  arpa_pkg::cmd_t                   cmd,
  output arpa_pkg::stat_t                  stat
);
  import arpa_pkg::*;

  logic [ADDR_W-1:0] base_r [MAX_REGIONS];
  logic [ADDR_W-1:0] size_r [MAX_REGIONS];
  logic [ADDR_W-1:0] used_r [MAX_REGIONS];
  logic [IDX_W-1:0]  lo_r   [MAX_REGIONS];

  logic [CNT_W-1:0]  count_r, p_r;
  logic [IDX_W-1:0]  s_r;
  logic [ADDR_W-1:0] bump_r, total_r, ra_r, len_r, addr_r, size_w_r, rem_r, frem_r;
  logic [CC_W-1:0]   cc_r;
  logic [1:0]        mode_r, stat_r;
  logic              new_r;
  logic [LEN_W-1:0]  init_cfg_r, incr_cfg_r;
  logic [CC_W-1:0]   ivl_cfg_r;
  logic              out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  logic [IDX_W-1:0]  ridx;
  logic [ADDR_W-1:0] rd_base, rd_size, rd_used, rd_room;
  logic [ADDR_W-1:0] inc_eff, incr0, incr, init_eff, q, mtf_diff, sz_diff;
  logic [ADDR_W-1:0] t10, frem10, sz10;
  logic [CC_W-1:0]   ivl_eff, dvsr;
  logic [ADDR_W-1:0] dvnd;
  logic              div_start, div_busy;

  // single read port into the region table
  always_comb begin
    case (cmd.rsel)
      RSEL_SLOT:  ridx = s_r;
      RSEL_FRONT: ridx = lo_r[0];
      default:    ridx = lo_r[p_r[IDX_W-1:0]];
    endcase
    rd_base = base_r[ridx];
    rd_size = size_r[ridx];
    rd_used = used_r[ridx];
    rd_room = rd_size - rd_used;
  end

  always_comb begin
    t10      = div10(total_r);
    frem10   = div10(frem_r);
    sz10     = div10(size_w_r);
    inc_eff  = pad8((incr_cfg_r == '0) ? DEF_INCR : ADDR_W'(incr_cfg_r));
    incr0    = (len_r > inc_eff) ? len_r : inc_eff;
    incr     = (incr0 < t10) ? pad8(t10) : incr0;
    init_eff = pad8((init_cfg_r == '0) ? DEF_INITIAL : ADDR_W'(init_cfg_r));
    if (init_eff > SPACE_SIZE) init_eff = SPACE_SIZE;
    ivl_eff  = (ivl_cfg_r == '0) ? DEF_INTERVAL : ivl_cfg_r;
    mtf_diff = rem_r - frem_r;
    sz_diff  = (ra_r > size_w_r) ? ra_r - size_w_r : size_w_r - ra_r;
  end

  // divider operand select, only the clear-count divisions go through it
  always_comb begin
    div_start = 1'b1;
    dvnd      = total_r;
    dvsr      = cc_r;
    case (cmd.op)
      OP_CLR_START: begin
        dvnd = ra_r;
        dvsr = cc_r + CC_W'(1);
      end
      OP_RA_SUB: begin
        dvnd = total_r;
        dvsr = cc_r;
      end
      default:      div_start = 1'b0;
    endcase
  end

  arpa_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dvnd),
    .divisor  (dvsr),
    .quotient (q),
    .busy     (div_busy)
  );

  always_comb begin
    stat.is_alloc    = (mode_r == MODE_ALLOC);
    stat.forced      = (mode_r == MODE_FORCE);
    stat.fits        = rd_room >= len_r;
    stat.scan_end    = (p_r == count_r);
    stat.table_full  = (count_r >= CNT_W'(MAX_REGIONS));
    stat.too_big     = incr > (SPACE_SIZE - bump_r);
    stat.p_zero      = (p_r == '0);
    stat.mtf_ok      = (rem_r > frem_r) &&
                       ((frem_r == '0) || ((mtf_diff > MTF_SLACK) && (mtf_diff > frem10)));
    stat.unused      = (count_r == CNT_W'(1)) && (rd_used == '0);
    stat.at_interval = (cc_r >= ivl_eff);
    stat.div_done    = !div_busy;
    stat.out_free    = !out_valid_r || out_tready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_cfg_r <= LEN_W'(512);
      incr_cfg_r <= LEN_W'(128);
      ivl_cfg_r  <= CC_W'(100);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_INITIAL:  init_cfg_r <= cfg_data;
        REG_INCR:     incr_cfg_r <= cfg_data;
        REG_INTERVAL: ivl_cfg_r  <= cfg_data[CC_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < MAX_REGIONS; k++) begin
        base_r[k] <= '0;
        size_r[k] <= (k == 0) ? DEF_INITIAL : '0;
        used_r[k] <= '0;
        lo_r[k]   <= IDX_W'(k);
      end
      count_r     <= CNT_W'(1);
      bump_r      <= DEF_INITIAL;
      total_r     <= '0;
      cc_r        <= '0;
      ra_r        <= '0;
      p_r         <= '0;
      s_r         <= '0;
      mode_r      <= MODE_ALLOC;
      stat_r      <= STAT_OK;
      new_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.op == OP_OUT) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
      case (cmd.op)
        OP_LOAD: begin
          mode_r <= in_tuser;
          len_r  <= pad8(ADDR_W'(in_tdata[LEN_W-1:0]));
          p_r    <= '0;
          s_r    <= '0;
          addr_r <= '0;
          new_r  <= 1'b0;
          stat_r <= STAT_OK;
        end
        OP_STEP:      p_r <= p_r + CNT_W'(1);
        OP_FOUND:     s_r <= ridx;
        OP_ERR_FULL:  stat_r <= STAT_FULL;
        OP_ERR_SPACE: stat_r <= STAT_SPACE;
        OP_APPEND: begin
          s_r                          <= count_r[IDX_W-1:0];
          p_r                          <= count_r;
          base_r[count_r[IDX_W-1:0]]   <= bump_r;
          size_r[count_r[IDX_W-1:0]]   <= incr;
          used_r[count_r[IDX_W-1:0]]   <= '0;
          lo_r[count_r[IDX_W-1:0]]     <= count_r[IDX_W-1:0];
          count_r                      <= count_r + CNT_W'(1);
          bump_r                       <= bump_r + incr;
          new_r                        <= 1'b1;
        end
        OP_GRANT: begin
          addr_r      <= rd_base + rd_used;
          used_r[s_r] <= rd_used + len_r;
          total_r     <= total_r + len_r;
          rem_r       <= rd_room - len_r;
        end
        OP_DIV_FREM: frem_r <= rd_room;
        OP_MTF: begin
          // shift list positions 0..p-1 down by one, serving slot to the front
          for (int k = 1; k < MAX_REGIONS; k++) begin
            if (CNT_W'(k) <= p_r) lo_r[k] <= lo_r[k-1];
          end
          lo_r[0] <= s_r;
        end
        OP_CLR_START: begin
          size_w_r <= rd_size;
          cc_r     <= cc_r + CC_W'(1);
        end
        OP_RA_SUB: ra_r <= ra_r - q;
        OP_RA_ADD: ra_r <= ra_r + q;
        OP_FORCE: begin
          size_w_r <= init_eff;
          cc_r     <= '0;
          ra_r     <= '0;
        end
        OP_RESIZE: begin
          if (sz_diff > sz10) size_w_r <= ra_r;
          cc_r <= '0;
          ra_r <= '0;
        end
        OP_RELOC: begin
          for (int k = 0; k < MAX_REGIONS; k++) begin
            lo_r[k] <= IDX_W'(k);
          end
          base_r[0] <= '0;
          size_r[0] <= size_w_r;
          used_r[0] <= '0;
          count_r   <= CNT_W'(1);
          bump_r    <= size_w_r;
          total_r   <= '0;
        end
        OP_OUT: begin
          out_data_r  <= {{(OUT_DATA_W - SPACE_BITS - IDX_W - 3){1'b0}},
                          stat_r, new_r, s_r, addr_r[SPACE_BITS-1:0]};
        end
        default: ;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != '0) && (count_r <= CNT_W'(MAX_REGIONS)))
    else $error("region count out of range");

  a_bump_range: assert property (@(posedge clk) disable iff (!rst_n)
    bump_r <= SPACE_SIZE)
    else $error("bump pointer past end of space");

  a_div_busy: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |=> div_busy)
    else $error("divider not busy after start");

endmodule

FILE: design/adaptive_region_pool_allocator_unit.sv
// adaptive_region_pool_allocator_unit: top level of the region pool allocator
// depends on arpa_pkg, arpa_ctrl, arpa_dp (and arpa_div below it)
//
//   channel  | direction | contents
//   in_      | in        | tuser: mode[1:0]; tdata: request_length[19:0]
//   out_     | out       | tdata: grant_address, region_index, new_region, status
//   cfg_     | in        | index 0 initial_size, 1 increment_size, 2 resize_interval
//
// allocate: the scan walks the region list to the first fit at list position N, and
// a move-to-front check follows if N is not zero; with no fit, a region is appended
// if table and space allow. clear: two serial divider passes by the clear count,
// none for an unused pool; division by ten is a combinational reciprocal multiply.
// one item at a time; in_tready is high only while idle, and a finished word waits
// in the output register while the next item is accepted.
// reset is synchronous, active low; cfg_ready is always high.
module adaptive_region_pool_allocator_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [arpa_pkg::IN_DATA_W-1:0]   in_tdata,   // request_length[19:0], zeros
  input  logic [1:0]                       in_tuser,   // mode[1:0]
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // grant_address[19:0], region_index[23:20], new_region[24], status[26:25], zeros
  output logic [arpa_pkg::OUT_DATA_W-1:0]  out_tdata,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [1:0]                       cfg_index,
  input  logic [arpa_pkg::LEN_W-1:0]       cfg_data
);
  import arpa_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  arpa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  arpa_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .stat       (stat)
  );

endmodule
